// File: src/bsdq_pkg.sv
// bsdq_pkg: shared types and codes for the bounded sorted deque.
// Used by bsdq_cell and bounded_sorted_deque; depends on nothing.
package bsdq_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned FUNC_W  = 3;
    localparam int unsigned COUNT_W = 5;
    localparam int unsigned STAT_W  = 2;

    // request codes; codes above FN_READ act as read
    localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_SORTED     = 3'd4;
    localparam logic [FUNC_W-1:0] FN_READ       = 3'd5;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    // command broadcast to every cell; at most one strobe is high
    typedef struct packed {
        logic                     push_front;
        logic                     pop_front;
        logic                     push_back;
        logic                     pop_back;
        logic                     sorted;
        logic signed [DATA_W-1:0] value;
    } t_cell_cmd;

endpackage

// File: src/bsdq_cell.sv
// bsdq_cell: one entry slot of the deque chain (value plus occupied flag).
// Depends on bsdq_pkg; instantiated in a row by bounded_sorted_deque.
module bsdq_cell
    import bsdq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cell_cmd                i_cmd,
    input  logic signed [DATA_W-1:0] i_left_val,
    input  logic                     i_left_valid,
    input  logic signed [DATA_W-1:0] i_right_val,
    input  logic                     i_right_valid,
    input  logic                     i_hit,
    output logic                     o_hit,
    input  logic signed [DATA_W-1:0] i_back,
    output logic signed [DATA_W-1:0] o_back,
    output logic signed [DATA_W-1:0] o_val,
    output logic                     o_valid
);

    logic signed [DATA_W-1:0] r_val;
    logic signed [DATA_W-1:0] n_val;
    logic                     r_valid;
    logic                     n_valid;
    logic                     w_gt;
    logic                     w_stop;

    // insert point: first slot that is empty or holds a larger value
    assign w_gt   = r_valid && (r_val > i_cmd.value);
    assign w_stop = !r_valid || w_gt;
    assign o_hit  = i_hit || w_stop;

    // last occupied value seen so far along the chain
    assign o_back  = r_valid ? r_val : i_back;
    assign o_val   = r_val;
    assign o_valid = r_valid;

    // next slot contents
    always_comb begin
        n_val   = r_val;
        n_valid = r_valid;
        if (i_cmd.push_front) begin
            n_val   = i_left_val;
            n_valid = i_left_valid;
        end else if (i_cmd.pop_front) begin
            n_val   = i_right_val;
            n_valid = i_right_valid;
        end else if (i_cmd.push_back) begin
            if (!r_valid && i_left_valid) begin
                n_val   = i_cmd.value;
                n_valid = 1'b1;
            end
        end else if (i_cmd.pop_back) begin
            n_valid = r_valid && i_right_valid;
        end else if (i_cmd.sorted) begin
            if (i_hit) begin
                n_val   = i_left_val;
                n_valid = i_left_valid;
            end else if (w_stop) begin
                n_val   = i_cmd.value;
                n_valid = 1'b1;
            end
        end
    end

    // occupied flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

// File: src/bounded_sorted_deque.sv
// Bounded ordered deque of signed 32-bit entries.
// Instantiates a row of DEPTH bsdq_cell slots; depends on bsdq_pkg.
//
// Usage:
//   Request channel i_valid / o_stall carries i_func and i_value; a
//   transaction completes on a rising edge with i_valid high, o_stall low.
//   Result channel o_valid / i_stall carries front, back, count, status;
//   one result per request, in request order.
//   Each request updates the cell row in the cycle it is accepted: every
//   slot shifts left, shifts right, holds or loads the new value at once,
//   so a new request can be taken every cycle while o_stall is low.
//   The row updates at the accepting edge; the request then waits in the pending
//   stage, which loads the output register once that register is not stalled.
//   The front/back values come from a ripple along the cell row, so the
//   longest path grows with DEPTH.
//   Reset (synchronous, active low) empties the list and drops any result
//   in flight; entry values are not cleared.
//   When the receiver stalls, the result holds; one more request is taken
//   into the pending stage, after which o_stall rises until the output
//   register drains.
module bounded_sorted_deque
    import bsdq_pkg::*;
#(
    parameter int unsigned DEPTH = 16
)(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [FUNC_W-1:0]         i_func,
    input  logic signed [DATA_W-1:0]  i_value,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [DATA_W-1:0]  o_front_value,
    output logic signed [DATA_W-1:0]  o_back_value,
    output logic [COUNT_W-1:0]        o_entry_count,
    output logic [STAT_W-1:0]         o_status
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic                     r_pend;
    logic [STAT_W-1:0]        r_pend_status;
    logic [STAT_W-1:0]        n_status;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_front;
    logic signed [DATA_W-1:0] r_back;
    logic [COUNT_W-1:0]       r_out_count;
    logic [STAT_W-1:0]        r_out_status;

    logic                     w_acc;
    logic                     w_pend_move;
    logic                     w_full;
    logic                     w_empty;
    logic                     w_is_push;
    t_cell_cmd                w_cmd;

    logic signed [DATA_W-1:0] w_val   [DEPTH];
    logic [DEPTH-1:0]         w_valid;
    logic [DEPTH:0]           w_hit;
    logic signed [DATA_W-1:0] w_back  [DEPTH+1];

    // handshake
    assign w_pend_move = r_pend && (!r_out_valid || !i_stall);
    assign o_stall     = r_pend && r_out_valid && i_stall;
    assign w_acc       = i_valid && !o_stall;

    assign w_full  = (r_count == FULL_CNT);
    assign w_empty = (r_count == '0);

    // request decode into cell command and result status
    always_comb begin
        w_cmd       = '0;
        w_cmd.value = i_value;
        w_is_push   = 1'b0;
        n_status    = ST_OK;
        n_count     = r_count;
        unique case (i_func)
            FN_PUSH_FRONT: begin
                w_is_push        = 1'b1;
                w_cmd.push_front = w_acc && !w_full;
            end
            FN_POP_FRONT:  w_cmd.pop_front = w_acc;
            FN_PUSH_BACK: begin
                w_is_push       = 1'b1;
                w_cmd.push_back = w_acc && !w_full;
            end
            FN_POP_BACK:   w_cmd.pop_back = w_acc;
            FN_SORTED: begin
                w_is_push    = 1'b1;
                w_cmd.sorted = w_acc && !w_full;
            end
            default: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end
            end
        endcase
        if (w_is_push && w_full) begin
            n_status = ST_FULL;
        end
        if (w_cmd.push_front || w_cmd.push_back || w_cmd.sorted) begin
            n_count = r_count + CNT_W'(1);
        end else if ((w_cmd.pop_front || w_cmd.pop_back) && !w_empty) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // chain ends
    assign w_hit[0]  = 1'b0;
    assign w_back[0] = '0;

    // row of cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_lval;
        logic                     w_lvalid;
        logic signed [DATA_W-1:0] w_rval;
        logic                     w_rvalid;

        if (g == 0) begin : g_first
            assign w_lval   = i_value;
            assign w_lvalid = 1'b1;
        end else begin : g_mid
            assign w_lval   = w_val[g-1];
            assign w_lvalid = w_valid[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_rval   = '0;
            assign w_rvalid = 1'b0;
        end else begin : g_inner
            assign w_rval   = w_val[g+1];
            assign w_rvalid = w_valid[g+1];
        end

        bsdq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (w_cmd),
            .i_left_val    (w_lval),
            .i_left_valid  (w_lvalid),
            .i_right_val   (w_rval),
            .i_right_valid (w_rvalid),
            .i_hit         (w_hit[g]),
            .o_hit         (w_hit[g+1]),
            .i_back        (w_back[g]),
            .o_back        (w_back[g+1]),
            .o_val         (w_val[g]),
            .o_valid       (w_valid[g])
        );
    end

    // count, pending stage and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_acc) begin
                r_pend <= 1'b1;
            end else if (w_pend_move) begin
                r_pend <= 1'b0;
            end
            if (w_pend_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_pend_status <= n_status;
        end
        if (w_pend_move) begin
            r_front      <= w_valid[0] ? w_val[0] : '0;
            r_back       <= w_back[DEPTH];
            r_out_count  <= COUNT_W'(r_count);
            r_out_status <= r_pend_status;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_front_value = r_front;
    assign o_back_value  = r_back;
    assign o_entry_count = r_out_count;
    assign o_status      = r_out_status;

`ifndef SYNTH
    // count never passes the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count above capacity");

    // occupied flags agree with the count
    a_valid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == 32'(r_count))
        else $error("cell occupancy does not match count");

    // a push into a full list leaves the count alone
    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_full && w_is_push) |=> $stable(r_count))
        else $error("push into full list changed count");
`endif

endmodule

// File: bench/bounded_sorted_deque_test.sv
// bounded_sorted_deque_test: self-checking bench for the bounded sorted deque.
// Directed table, then random fill/drain traffic with stalls on both sides.
// Depends on bsdq_pkg and bounded_sorted_deque.
`timescale 1ns / 100ps

module bounded_sorted_deque_test;
    import bsdq_pkg::*;

    localparam int unsigned LIST_DEPTH     = 16;
    localparam int unsigned RANDOM_ITEMS   = 1125;
    localparam int unsigned DRAIN_AT       = 520;
    localparam int unsigned LONG_HOLD      = 120;
    localparam int unsigned HOLD_SPACING   = 450;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned WATCHDOG_LIMIT = 1000;

    // spare request codes; the block treats them as reads
    localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;

    typedef logic signed [DATA_W-1:0] t_word;

    localparam t_word WORD_MAX = 32'sh7fffffff;
    localparam t_word WORD_MIN = 32'sh80000000;

    typedef struct packed {
        t_word               front;
        t_word               back;
        logic [COUNT_W-1:0]  count;
        logic [STAT_W-1:0]   status;
    } t_deque_result;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        t_word               value;
        logic                typed;
        t_deque_result       want;
    } t_directed_row;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic [FUNC_W-1:0]  i_func  = FN_READ;
    t_word              i_value = '0;
    logic               i_stall = 1'b0;
    logic               o_stall;
    logic               o_valid;
    t_word              o_front_value;
    t_word              o_back_value;
    logic [COUNT_W-1:0] o_entry_count;
    logic [STAT_W-1:0]  o_status;

    // predicted list contents and the results still owed by the block
    t_word              held_entries[$];
    t_deque_result      owed_results[$];
    t_deque_result      head_result;
    t_directed_row      directed_plan[$];

    int unsigned        mismatch_count  = 0;
    int unsigned        requests_sent   = 0;
    int unsigned        results_checked = 0;
    int unsigned        full_rejects    = 0;
    int unsigned        empty_reads     = 0;

    bounded_sorted_deque #(
        .DEPTH(LIST_DEPTH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_func(i_func),
        .i_value(i_value),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_front_value(o_front_value),
        .o_back_value(o_back_value),
        .o_entry_count(o_entry_count),
        .o_status(o_status)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // apply one request to the predicted list and return the result it owes
    function automatic t_deque_result apply_request(input logic [FUNC_W-1:0] func,
                                                    input t_word value);
        t_deque_result r;
        int unsigned slot;
        r = '0;
        r.status = ST_OK;
        case (func)
            FN_PUSH_FRONT: begin
                if (held_entries.size() >= LIST_DEPTH) r.status = ST_FULL;
                else held_entries.push_front(value);
            end
            FN_POP_FRONT: begin
                if (held_entries.size() != 0) void'(held_entries.pop_front());
            end
            FN_PUSH_BACK: begin
                if (held_entries.size() >= LIST_DEPTH) r.status = ST_FULL;
                else held_entries.push_back(value);
            end
            FN_POP_BACK: begin
                if (held_entries.size() != 0) void'(held_entries.pop_back());
            end
            FN_SORTED: begin
                if (held_entries.size() >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    // goes before the first entry greater than it
                    slot = 0;
                    while (slot < held_entries.size() && held_entries[slot] <= value)
                        slot++;
                    held_entries.insert(slot, value);
                end
            end
            default: begin
                if (held_entries.size() == 0) r.status = ST_EMPTY;
            end
        endcase
        if (r.status == ST_FULL) full_rejects++;
        if (r.status == ST_EMPTY) empty_reads++;
        if (held_entries.size() != 0) begin
            r.front = held_entries[0];
            r.back  = held_entries[held_entries.size() - 1];
        end
        r.count = COUNT_W'(held_entries.size());
        return r;
    endfunction

    function automatic t_directed_row row_checked(input logic [FUNC_W-1:0] func,
                                                  input t_word value,
                                                  input t_word front,
                                                  input t_word back,
                                                  input logic [COUNT_W-1:0] count,
                                                  input logic [STAT_W-1:0] status);
        t_directed_row row;
        row.func         = func;
        row.value        = value;
        row.typed        = 1'b1;
        row.want.front   = front;
        row.want.back    = back;
        row.want.count   = count;
        row.want.status  = status;
        return row;
    endfunction

    function automatic t_directed_row row_predicted(input logic [FUNC_W-1:0] func,
                                                    input t_word value);
        t_directed_row row;
        row       = '0;
        row.func  = func;
        row.value = value;
        return row;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int unsigned pick_idle();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(3, 1);
        if (roll < 97) return $urandom_range(12, 4);
        return $urandom_range(40, 13);
    endfunction

    // request mix leans to pushes while filling and to pops while draining
    function automatic logic [FUNC_W-1:0] pick_func(input bit filling);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < (filling ? 70 : 20)) begin
            case ($urandom_range(3))
                0:       return FN_PUSH_FRONT;
                1:       return FN_PUSH_BACK;
                default: return FN_SORTED;
            endcase
        end
        if (roll < 85) return ($urandom_range(1) != 0) ? FN_POP_FRONT : FN_POP_BACK;
        case ($urandom_range(2))
            0:       return FN_READ;
            1:       return FN_SPARE_6;
            default: return FN_SPARE_7;
        endcase
    endfunction

    // values: full range, a narrow band for ties, extremes, moderate spread
    function automatic t_word pick_value();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 30) return $urandom;
        if (roll < 70) return $signed($urandom_range(8)) - 4;
        if (roll < 85) begin
            case ($urandom_range(3))
                0:       return WORD_MAX;
                1:       return WORD_MIN;
                2:       return '0;
                default: return '1;
            endcase
        end
        return $signed($urandom_range(2000)) - 1000;
    endfunction

    // offer one transaction, hold it until taken, then idle or wait for drain
    task automatic offer_request(input logic [FUNC_W-1:0] func,
                                 input t_word value,
                                 input logic typed,
                                 input t_deque_result typed_result,
                                 input int unsigned idle,
                                 input bit drain);
        t_deque_result predicted;
        i_func  <= func;
        i_value <= value;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predicted = apply_request(func, value);
        owed_results.push_back(typed ? typed_result : predicted);
        requests_sent++;
        if (idle != 0 || drain) begin
            i_valid <= 1'b0;
            repeat (idle) @(posedge i_clk);
            while (drain && owed_results.size() != 0) @(posedge i_clk);
        end
    endtask

    // result side: compare each accepted transaction with the oldest owed result
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (owed_results.size() == 0) begin
                $error("unexpected result: front_value %0d back_value %0d count %0d",
                       o_front_value, o_back_value, o_entry_count);
                mismatch_count++;
            end else begin
                head_result = owed_results.pop_front();
                results_checked++;
                if (o_front_value !== head_result.front) begin
                    $error("front_value: expected %0d, actual %0d",
                           head_result.front, o_front_value);
                    mismatch_count++;
                end
                if (o_back_value !== head_result.back) begin
                    $error("back_value: expected %0d, actual %0d",
                           head_result.back, o_back_value);
                    mismatch_count++;
                end
                if (o_entry_count !== head_result.count) begin
                    $error("entry_count: expected %0d, actual %0d",
                           head_result.count, o_entry_count);
                    mismatch_count++;
                end
                if (o_status !== head_result.status) begin
                    $error("status: expected %0d, actual %0d",
                           head_result.status, o_status);
                    mismatch_count++;
                end
            end
        end
    end

    // result side stall pattern, with a long hold every few hundred results
    initial begin : result_sink
        int unsigned run;
        int unsigned hold;
        int unsigned next_hold_at;
        next_hold_at = 300;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            run = ($urandom_range(4) == 0) ? $urandom_range(60, 20) : $urandom_range(6, 1);
            repeat (run) begin
                @(posedge i_clk);
                i_stall <= 1'b0;
            end
            if (results_checked >= next_hold_at) begin
                hold = LONG_HOLD;
                next_hold_at += HOLD_SPACING;
            end else begin
                hold = pick_idle();
            end
            repeat (hold) begin
                @(posedge i_clk);
                i_stall <= 1'b1;
            end
        end
    end

    // end the run if no transaction moves for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet = 0;
            else quiet++;
        end
        $display("Mismatches found");
        $finish;
    end

    // request side: reset, directed table, then random traffic
    initial begin : request_source
        int unsigned item;
        int unsigned idle;
        int unsigned phase_left;
        int unsigned burst_left;
        bit          filling;

        // empty list: reads flag, pops do nothing
        directed_plan.push_back(row_checked(FN_READ, 0, 0, 0, 5'd0, ST_EMPTY));
        directed_plan.push_back(row_checked(FN_POP_FRONT, 123, 0, 0, 5'd0, ST_OK));
        directed_plan.push_back(row_checked(FN_POP_BACK, -1, 0, 0, 5'd0, ST_OK));
        directed_plan.push_back(row_checked(FN_SPARE_6, WORD_MAX, 0, 0, 5'd0, ST_EMPTY));
        directed_plan.push_back(row_checked(FN_SPARE_7, WORD_MIN, 0, 0, 5'd0, ST_EMPTY));
        // extremes at both ends
        directed_plan.push_back(row_checked(FN_PUSH_BACK, WORD_MAX,
                                            WORD_MAX, WORD_MAX, 5'd1, ST_OK));
        directed_plan.push_back(row_checked(FN_PUSH_FRONT, WORD_MIN,
                                            WORD_MIN, WORD_MAX, 5'd2, ST_OK));
        // sorted inserts, ties against zero and both extremes
        directed_plan.push_back(row_predicted(FN_SORTED, 0));
        directed_plan.push_back(row_predicted(FN_SORTED, -1));
        directed_plan.push_back(row_predicted(FN_SORTED, 0));
        directed_plan.push_back(row_predicted(FN_SORTED, WORD_MAX));
        directed_plan.push_back(row_predicted(FN_SORTED, WORD_MIN));
        directed_plan.push_back(row_predicted(FN_SORTED, 5));
        directed_plan.push_back(row_predicted(FN_SORTED, -5));
        directed_plan.push_back(row_predicted(FN_SORTED, 1));
        directed_plan.push_back(row_predicted(FN_SORTED, 100));
        directed_plan.push_back(row_predicted(FN_SORTED, -100));
        directed_plan.push_back(row_predicted(FN_SORTED, 7));
        directed_plan.push_back(row_predicted(FN_SORTED, 42));
        directed_plan.push_back(row_predicted(FN_SORTED, 3));
        directed_plan.push_back(row_predicted(FN_SORTED, -3));
        // full list: every push is refused
        directed_plan.push_back(row_checked(FN_PUSH_FRONT, 9,
                                            WORD_MIN, WORD_MAX, 5'd16, ST_FULL));
        directed_plan.push_back(row_checked(FN_PUSH_BACK, 9,
                                            WORD_MIN, WORD_MAX, 5'd16, ST_FULL));
        directed_plan.push_back(row_checked(FN_SORTED, 9,
                                            WORD_MIN, WORD_MAX, 5'd16, ST_FULL));
        directed_plan.push_back(row_checked(FN_READ, -1,
                                            WORD_MIN, WORD_MAX, 5'd16, ST_OK));
        directed_plan.push_back(row_predicted(FN_POP_BACK, 77));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_plan[n]) begin
            offer_request(directed_plan[n].func, directed_plan[n].value,
                          directed_plan[n].typed, directed_plan[n].want,
                          pick_idle(), n == directed_plan.size() - 1);
        end

        // random part: alternate filling and draining phases
        filling    = 1'b0;
        phase_left = 0;
        burst_left = 0;
        for (item = 0; item < RANDOM_ITEMS; item++) begin
            if (phase_left == 0) begin
                filling    = !filling;
                phase_left = $urandom_range(40, 10);
            end
            phase_left--;
            if (burst_left != 0) begin
                idle = 0;
                burst_left--;
            end else begin
                idle = pick_idle();
                if ($urandom_range(60) == 0) burst_left = $urandom_range(40, 15);
            end
            offer_request(pick_func(filling), pick_value(), 1'b0, '0, idle,
                          item == DRAIN_AT || item == RANDOM_ITEMS - 1);
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d requests (%0d directed), checked %0d results.",
                 requests_sent, directed_plan.size(), results_checked);
        $display("Pushes refused on a full list: %0d; reads of an empty list: %0d.",
                 full_rejects, empty_reads);
        if (mismatch_count == 0 && owed_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: sim.f
src/bsdq_pkg.sv
src/bsdq_cell.sv
src/bounded_sorted_deque.sv
bench/bounded_sorted_deque_test.sv
